/* rtl/vqdm_pkg.sv */
// Package: shared types and constants for the virtqueue descriptor manager.
`timescale 1ns / 1ps

package vqdm_pkg;

  // Descriptor flag bits
  localparam logic [1:0] FLAG_NEXT  = 2'b01;
  localparam logic [1:0] FLAG_WRITE = 2'b10;

  // Operation codes
  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Reset value of the sectors-per-block register
  localparam logic [3:0] SPB_RESET = 4'd2;

  typedef struct packed {
    logic        op;
    logic        is_write;
    logic [31:0] block_number;
    logic [2:0]  release_head;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        fault;
    logic [2:0]  head_index;
    logic [2:0]  data_index;
    logic [2:0]  status_index;
    logic        device_writes_data;
    logic        request_type;
    logic [34:0] sector;
    logic [2:0]  avail_slot;
    logic [15:0] avail_count;
    logic [3:0]  freed_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK0,
    ST_PICK1,
    ST_PICK2,
    ST_SUB_FIN,
    ST_WALK_CHK,
    ST_WALK_LINK,
    ST_REL_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic pick0;
    logic pick1;
    logic pick2;
    logic sub_finish;
    logic walk_check;
    logic walk_follow;
    logic rel_finish;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic walk_hit;
    logic link_more;
  } dp_status_t;

endpackage

/* rtl/vqdm_ctrl.sv */
// Controller: sequences submit allocation and release chain walks.
`timescale 1ns / 1ps

module vqdm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  vqdm_pkg::dp_status_t status,
  output vqdm_pkg::dp_cmd_t    cmd
);

  vqdm_pkg::state_t state_r;
  vqdm_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vqdm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vqdm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == vqdm_pkg::OP_SUBMIT) ? vqdm_pkg::ST_PICK0
                                                     : vqdm_pkg::ST_WALK_CHK;
        end
      end
      vqdm_pkg::ST_PICK0:    state_nxt = vqdm_pkg::ST_PICK1;
      vqdm_pkg::ST_PICK1:    state_nxt = vqdm_pkg::ST_PICK2;
      vqdm_pkg::ST_PICK2:    state_nxt = vqdm_pkg::ST_SUB_FIN;
      vqdm_pkg::ST_SUB_FIN: begin
        if (status.out_free) state_nxt = vqdm_pkg::ST_IDLE;
      end
      vqdm_pkg::ST_WALK_CHK: begin
        state_nxt = status.walk_hit ? vqdm_pkg::ST_WALK_LINK : vqdm_pkg::ST_REL_FIN;
      end
      vqdm_pkg::ST_WALK_LINK: begin
        state_nxt = status.link_more ? vqdm_pkg::ST_WALK_CHK : vqdm_pkg::ST_REL_FIN;
      end
      vqdm_pkg::ST_REL_FIN: begin
        if (status.out_free) state_nxt = vqdm_pkg::ST_IDLE;
      end
      default: state_nxt = vqdm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      vqdm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vqdm_pkg::ST_PICK0:     cmd.pick0 = 1'b1;
      vqdm_pkg::ST_PICK1:     cmd.pick1 = 1'b1;
      vqdm_pkg::ST_PICK2:     cmd.pick2 = 1'b1;
      vqdm_pkg::ST_SUB_FIN:   cmd.sub_finish = status.out_free;
      vqdm_pkg::ST_WALK_CHK:  cmd.walk_check = 1'b1;
      vqdm_pkg::ST_WALK_LINK: cmd.walk_follow = status.link_more;
      vqdm_pkg::ST_REL_FIN:   cmd.rel_finish = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

/* rtl/vqdm_datapath.sv */
// Datapath: free map, link table, pick logic, sector multiply and result register.
`timescale 1ns / 1ps

module vqdm_datapath #(
  parameter int QUEUE_ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vqdm_pkg::in_item_t   in_data,
  input  logic                 cfg_valid,
  input  logic [3:0]           cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output vqdm_pkg::out_item_t  out_data,
  input  vqdm_pkg::dp_cmd_t    cmd,
  output vqdm_pkg::dp_status_t status
);

  localparam int IDX_W  = $clog2(QUEUE_ENTRIES);
  localparam int CUR_W  = (IDX_W > 3) ? IDX_W : 3;
  localparam int CNT_W  = $clog2(QUEUE_ENTRIES + 1);
  localparam int LINK_W = IDX_W + 2;
  localparam logic [CUR_W:0]   CUR_LIMIT = (CUR_W + 1)'(QUEUE_ENTRIES);
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(QUEUE_ENTRIES - 1);

  // Configuration register
  logic [3:0] spb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r <= vqdm_pkg::SPB_RESET;
    end else if (cfg_valid) begin
      spb_r <= cfg_data;
    end
  end

  // Captured request
  vqdm_pkg::in_item_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
  end

  // Sector product, registered
  logic [35:0] prod;
  logic [34:0] sector_r;

  assign prod = 36'(req_r.block_number) * 36'(spb_r);

  always_ff @(posedge clk) begin
    if (cmd.pick0) sector_r <= prod[34:0];
  end

  // Free map and lowest-free search over entries not yet taken
  logic [QUEUE_ENTRIES-1:0] free_map_r, free_map_nxt;
  logic [QUEUE_ENTRIES-1:0] taken_r, taken_nxt;
  logic [QUEUE_ENTRIES-1:0] cand;
  logic                     pick_found;
  logic [IDX_W-1:0]         pick_idx;

  assign cand = free_map_r & ~taken_r;

  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = QUEUE_ENTRIES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_found = 1'b1;
        pick_idx   = IDX_W'(i);
      end
    end
  end

  // Picked descriptors
  logic [IDX_W-1:0] p0_r, p1_r, p2_r;
  logic [2:0]       found_r;
  logic             alloc_ok;

  assign alloc_ok = &found_r;

  always_ff @(posedge clk) begin
    if (cmd.pick0) p0_r <= pick_idx;
    if (cmd.pick1) p1_r <= pick_idx;
    if (cmd.pick2) p2_r <= pick_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
      taken_r <= '0;
    end else begin
      taken_r <= taken_nxt;
      if (cmd.load)  found_r <= '0;
      if (cmd.pick0) found_r[0] <= pick_found;
      if (cmd.pick1) found_r[1] <= pick_found;
      if (cmd.pick2) found_r[2] <= pick_found;
    end
  end

  always_comb begin
    taken_nxt = taken_r;
    if (cmd.load) begin
      taken_nxt = '0;
    end else if ((cmd.pick0 || cmd.pick1 || cmd.pick2) && pick_found) begin
      taken_nxt[pick_idx] = 1'b1;
    end
  end

  // Walk cursor and counters
  logic [CUR_W-1:0] cur_r;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_hit;
  logic [CNT_W-1:0] freed_r;
  logic             fault_r;

  assign cur_idx = cur_r[IDX_W-1:0];
  assign cur_hit = ({1'b0, cur_r} < CUR_LIMIT) && !free_map_r[cur_idx];

  // Link table: {flags, next}; an entry's read value is only used while allocated
  logic [LINK_W-1:0] link_mem [QUEUE_ENTRIES];
  logic [LINK_W-1:0] link_rd_r;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [1:0]        data_flags;

  assign data_flags = req_r.is_write ? vqdm_pkg::FLAG_NEXT
                                     : (vqdm_pkg::FLAG_NEXT | vqdm_pkg::FLAG_WRITE);

  // Header link once data index is known, data link once status index is known,
  // status link at commit; writes to entries still free are harmless.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = p0_r;
    link_wdata = {vqdm_pkg::FLAG_NEXT, pick_idx};
    if (cmd.pick1) begin
      link_we    = found_r[0];
      link_waddr = p0_r;
      link_wdata = {vqdm_pkg::FLAG_NEXT, pick_idx};
    end else if (cmd.pick2) begin
      link_we    = found_r[1];
      link_waddr = p1_r;
      link_wdata = {data_flags, pick_idx};
    end else if (cmd.sub_finish) begin
      link_we    = alloc_ok;
      link_waddr = p2_r;
      link_wdata = {vqdm_pkg::FLAG_WRITE, {IDX_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd.walk_check) link_rd_r <= link_mem[cur_idx];
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r   <= CUR_W'(in_data.release_head);
      freed_r <= '0;
      fault_r <= 1'b0;
    end else begin
      if (cmd.walk_check) begin
        if (cur_hit) freed_r <= freed_r + CNT_W'(1);
        else         fault_r <= 1'b1;
      end
      if (cmd.walk_follow) cur_r <= CUR_W'(link_rd_r[IDX_W-1:0]);
    end
  end

  // Free map update
  always_comb begin
    free_map_nxt = free_map_r;
    if (cmd.walk_check && cur_hit) begin
      free_map_nxt[cur_idx] = 1'b1;
    end else if (cmd.sub_finish && alloc_ok) begin
      free_map_nxt = free_map_r & ~taken_r;
    end
  end

  // Available index and ring slot (slot tracks index mod entries, wraps with index)
  logic [15:0]      avail_index_r;
  logic [IDX_W-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r    <= '1;
      avail_index_r <= '0;
      slot_r        <= '0;
    end else begin
      free_map_r <= free_map_nxt;
      if (cmd.sub_finish && alloc_ok) begin
        avail_index_r <= avail_index_r + 16'd1;
        if (avail_index_r == 16'hFFFF || slot_r == SLOT_LAST) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + IDX_W'(1);
        end
      end
    end
  end

  // Result register
  logic                out_valid_r;
  vqdm_pkg::out_item_t out_data_r, out_data_nxt;

  assign status.out_free  = !out_valid_r || out_ready;
  assign status.walk_hit  = cur_hit;
  assign status.link_more = (link_rd_r[IDX_W+1:IDX_W] & vqdm_pkg::FLAG_NEXT) != 2'b00;

  always_comb begin
    out_data_nxt = '0;
    if (cmd.sub_finish && alloc_ok) begin
      out_data_nxt.accepted           = 1'b1;
      out_data_nxt.head_index         = 3'(p0_r);
      out_data_nxt.data_index         = 3'(p1_r);
      out_data_nxt.status_index       = 3'(p2_r);
      out_data_nxt.device_writes_data = !req_r.is_write;
      out_data_nxt.request_type       = req_r.is_write;
      out_data_nxt.sector             = sector_r;
      out_data_nxt.avail_slot         = 3'(slot_r);
      out_data_nxt.avail_count        = avail_index_r + 16'd1;
    end else if (cmd.rel_finish) begin
      out_data_nxt.fault       = fault_r;
      out_data_nxt.freed_count = 4'(freed_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sub_finish || cmd.rel_finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sub_finish || cmd.rel_finish) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/virtqueue_descriptor_manager.sv */
// Top level: descriptor manager of a split virtqueue for block requests.
//
// Channels: in_* carries one request transaction (submit or release chain),
// out_* returns exactly one result transaction per request, cfg_* writes the
// sectors-per-block register (always ready; write only while the block is idle).
// Requests are handled one at a time; in_ready is high only between requests.
// Submit: three picking cycles (lowest free descriptor each, one per cycle)
// and a commit cycle, so the result is valid 4 cycles after acceptance and a
// new request may be taken 5 cycles after the previous one.
// Release: two cycles per chain entry freed (free-map check, then link-table
// read through the single registered read port), one more check when the walk
// ends on a fault, and a final step: the result is valid 2*N + 1 cycles after
// acceptance for N entries freed (2*N + 2 when the walk ends on a fault), and
// the next request may be taken one cycle after that.
// The result sits in an output register; while the receiver stalls the block
// holds its final step and takes no new request until the register drains.
// Reset (synchronous, rst_n low): all descriptors free, available index zero,
// sectors per block 2, output empty. The link table is not cleared; an entry's
// read value is used only after a submit has written it.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager #(
  parameter int QUEUE_ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vqdm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vqdm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  vqdm_pkg::dp_cmd_t    cmd;
  vqdm_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  vqdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  vqdm_datapath #(
    .QUEUE_ENTRIES (QUEUE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* tb/sv/tb_virtqueue_descriptor_manager.sv */
// Testbench for the virtqueue descriptor manager: directed and random requests.
`timescale 1ns / 1ps

module tb_virtqueue_descriptor_manager;

  localparam int NUM_DESC      = 8;
  localparam int DESCS_PER_REQ = 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int END_PAUSE     = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  vqdm_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vqdm_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_data  = '0;

  // Idle percentages for each side
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;

  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;

  // Predicted descriptor table and ring state
  logic        desc_free  [NUM_DESC];
  logic [2:0]  desc_next  [NUM_DESC];
  logic [1:0]  desc_flags [NUM_DESC];
  logic [15:0] avail_idx;
  logic [3:0]  spb_model;
  logic [2:0]  live_heads [$];
  logic [2:0]  last_head;

  vqdm_pkg::out_item_t pending_results [$];
  vqdm_pkg::out_item_t want_res;

  always #6 clk = ~clk;

  virtqueue_descriptor_manager #(.QUEUE_ENTRIES(NUM_DESC)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Descriptor table state after reset
  function automatic void clear_descriptor_model();
    for (int k = 0; k < NUM_DESC; k++) begin
      desc_free[k]  = 1'b1;
      desc_next[k]  = '0;
      desc_flags[k] = '0;
    end
    avail_idx = '0;
    spb_model = vqdm_pkg::SPB_RESET;
    live_heads.delete();
    last_head = '0;
  endfunction

  // Expected result of one request; updates the predicted table
  function automatic vqdm_pkg::out_item_t predict_descriptor_op(
    input vqdm_pkg::in_item_t req);
    vqdm_pkg::out_item_t res;
    logic [2:0]  pick [DESCS_PER_REQ];
    int          found;
    int          steps;
    logic        walking;
    logic [2:0]  cur;
    logic [2:0]  nxt;
    logic [1:0]  fl;
    logic [35:0] product;
    logic [2:0]  kept [$];
    res = '0;
    if (req.op == vqdm_pkg::OP_SUBMIT) begin
      found = 0;
      for (int k = 0; k < NUM_DESC; k++) begin
        if (desc_free[k] && found < DESCS_PER_REQ) begin
          pick[found] = k[2:0];
          found++;
        end
      end
      // Fewer than three free: rejected, all fields zero
      if (found == DESCS_PER_REQ) begin
        for (int k = 0; k < DESCS_PER_REQ; k++) desc_free[pick[k]] = 1'b0;
        desc_flags[pick[0]] = vqdm_pkg::FLAG_NEXT;
        desc_next[pick[0]]  = pick[1];
        desc_flags[pick[1]] = vqdm_pkg::FLAG_NEXT |
                              (req.is_write ? 2'b00 : vqdm_pkg::FLAG_WRITE);
        desc_next[pick[1]]  = pick[2];
        desc_flags[pick[2]] = vqdm_pkg::FLAG_WRITE;
        desc_next[pick[2]]  = '0;
        product = {4'b0, req.block_number} * {32'b0, spb_model};
        res.accepted           = 1'b1;
        res.head_index         = pick[0];
        res.data_index         = pick[1];
        res.status_index       = pick[2];
        res.device_writes_data = ~req.is_write;
        res.request_type       = req.is_write;
        res.sector             = product[34:0];
        res.avail_slot         = avail_idx[2:0];
        avail_idx              = avail_idx + 16'd1;
        res.avail_count        = avail_idx;
        live_heads.push_back(pick[0]);
        last_head = pick[0];
      end
    end else begin
      // Chain walk; stops on an already-free entry or at the end of the chain
      cur     = req.release_head;
      walking = 1'b1;
      steps   = 0;
      while (walking && steps <= NUM_DESC) begin
        if (desc_free[cur]) begin
          res.fault = 1'b1;
          walking   = 1'b0;
        end else begin
          fl  = desc_flags[cur];
          nxt = desc_next[cur];
          desc_flags[cur] = '0;
          desc_next[cur]  = '0;
          desc_free[cur]  = 1'b1;
          res.freed_count = res.freed_count + 4'd1;
          if ((fl & vqdm_pkg::FLAG_NEXT) == 2'b00) walking = 1'b0;
          else cur = nxt;
        end
        steps++;
      end
      foreach (live_heads[i]) if (!desc_free[live_heads[i]]) kept.push_back(live_heads[i]);
      live_heads = kept;
    end
    return res;
  endfunction

  function automatic vqdm_pkg::in_item_t make_request(input logic op, input logic is_write,
                                                      input logic [31:0] block,
                                                      input logic [2:0] head);
    vqdm_pkg::in_item_t r;
    r.op           = op;
    r.is_write     = is_write;
    r.block_number = block;
    r.release_head = head;
    return r;
  endfunction

  // Drive one request transaction; predict it when it is accepted
  task automatic send_request(input vqdm_pkg::in_item_t req);
    cfg_valid <= 1'b0;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_descriptor_op(req));
  endtask

  // Drop the request line, then wait until every pending result has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_spb(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    spb_model = value;
  endtask

  function automatic void check_field(input string name, input logic [34:0] want,
                                      input logic [34:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request pending");
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("accepted", want_res.accepted, out_data.accepted);
        check_field("fault", want_res.fault, out_data.fault);
        check_field("head_index", want_res.head_index, out_data.head_index);
        check_field("data_index", want_res.data_index, out_data.data_index);
        check_field("status_index", want_res.status_index, out_data.status_index);
        check_field("device_writes_data", want_res.device_writes_data,
                    out_data.device_writes_data);
        check_field("request_type", want_res.request_type, out_data.request_type);
        check_field("sector", want_res.sector, out_data.sector);
        check_field("avail_slot", want_res.avail_slot, out_data.avail_slot);
        check_field("avail_count", want_res.avail_count, out_data.avail_count);
        check_field("freed_count", want_res.freed_count, out_data.freed_count);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Watchdog: consecutive cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset value of sectors per block; read and write submits fill six entries
  task automatic test_reset_state();
    send_request(make_request(vqdm_pkg::OP_SUBMIT, 1'b0, 32'd1, 3'd0));
    send_request(make_request(vqdm_pkg::OP_SUBMIT, 1'b1, 32'hFFFF_FFFF, 3'd0));
  endtask

  // Submit with two free entries is rejected; freeing a chain lets it through
  task automatic test_table_exhaustion();
    send_request(make_request(vqdm_pkg::OP_SUBMIT, 1'b0, 32'h1234_5678, 3'd5));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, 3'd0));
    send_request(make_request(vqdm_pkg::OP_SUBMIT, 1'b0, 32'h0000_00FF, 3'd0));
  endtask

  // Double release, release from the middle of a chain, never-used entry
  task automatic test_release_faults();
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, 3'd3));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, 3'd3));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, 3'd1));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, 3'd0));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b1, 32'hFFFF_FFFF, 3'd7));
  endtask

  // Fields outside the operation must not matter
  task automatic test_ignored_fields();
    send_request(make_request(vqdm_pkg::OP_SUBMIT, 1'b1, 32'hA5A5_5A5A, 3'd7));
    send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b1, 32'hFFFF_FFFF, last_head));
  endtask

  // Register extremes, including zero and product overflow past 35 bits
  task automatic test_sector_scaling();
    logic [3:0] spb_set [4];
    spb_set = '{4'd0, 4'd1, 4'd8, 4'd15};
    foreach (spb_set[i]) begin
      wait_idle();
      write_spb(spb_set[i]);
      send_request(make_request(vqdm_pkg::OP_SUBMIT, i[0], 32'hFFFF_FFFF, 3'd0));
      send_request(make_request(vqdm_pkg::OP_RELEASE, 1'b0, '0, last_head));
    end
  endtask

  // Mostly well-formed submit/release traffic, with some noise
  function automatic vqdm_pkg::in_item_t random_request();
    vqdm_pkg::in_item_t r;
    int unsigned roll;
    r.is_write     = 1'($urandom_range(0, 1));
    r.release_head = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       r.block_number = '0;
      1:       r.block_number = 32'hFFFF_FFFF;
      default: r.block_number = $urandom();
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r.op = vqdm_pkg::OP_SUBMIT;
    end else if (roll < 88 && live_heads.size() != 0) begin
      r.op           = vqdm_pkg::OP_RELEASE;
      r.release_head = live_heads[$urandom_range(0, live_heads.size() - 1)];
    end else begin
      r.op = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct,
                                     input logic [3:0] spb, input int count);
    wait_idle();
    write_spb(spb);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    clear_descriptor_model();
    in_idle_pct  = 13;
    out_idle_pct = 74;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_table_exhaustion();
    test_release_faults();
    test_ignored_fields();
    test_sector_scaling();
    test_random_traffic(13, 74, 4'($urandom_range(1, 8)), 170);
    test_random_traffic(74, 13, 4'($urandom_range(0, 15)), 170);
    test_random_traffic(0, 0, 4'd8, 170);

    // Drain, then look for stray results
    wait_idle();
    cfg_valid <= 1'b0;
    repeat (END_PAUSE) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
